[rtl/khb_pkg.sv]
// ----------------------------------------------------------------------------
// khb_pkg: shared types and constants for the keyed hash bucket insert block
// Hash constants, message schedule table, status codes and command structs.
// ----------------------------------------------------------------------------
package khb_pkg;

	localparam int NONCE_LEN_DEF    = 4;
	localparam int PREFIX_BYTES_DEF = 2;
	localparam int BUCKET_AW        = 16;
	localparam int ROUNDS           = 7;
	localparam int NUM_REGS         = 6;

	localparam logic [2:0] REG_KEY01 = 3'd0;
	localparam logic [2:0] REG_KEY23 = 3'd1;
	localparam logic [2:0] REG_KEY45 = 3'd2;
	localparam logic [2:0] REG_KEY67 = 3'd3;
	localparam logic [2:0] REG_RPB   = 3'd4;
	localparam logic [2:0] REG_LIMIT = 3'd5;

	localparam logic [1:0] ST_STORED = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	localparam logic [31:0] FLAGS_KEYED = 32'h0000_001B;
	localparam logic [31:0] IV0 = 32'h6A09E667;
	localparam logic [31:0] IV1 = 32'hBB67AE85;
	localparam logic [31:0] IV2 = 32'h3C6EF372;
	localparam logic [31:0] IV3 = 32'hA54FF53A;

	typedef logic [31:0] word_t;

	// message word index used by word slot i in round r (composed permutation)
	function automatic logic [3:0] msg_sel(input logic [2:0] r, input logic [3:0] i);
		logic [3:0] perm [16];
		logic [3:0] k;
		perm = '{4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
			4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8};
		k = i;
		for (int j = 0; j < ROUNDS; j++) begin
			if (j < int'(r)) k = perm[k];
		end
		return k;
	endfunction

	typedef struct packed {
		logic start;     // load state from key and nonce
		logic half;      // run one half-round (4 G in parallel)
		logic diag;      // diagonal half when set
		logic [2:0] rnd;
		logic mem_rd;    // issue counter read
		logic mem_wr;    // write updated counter and capture result
	} khb_cmd_t;

	typedef struct packed {
		logic in_range;
	} khb_sts_t;

endpackage

[rtl/khb_stream_if.sv]
// ----------------------------------------------------------------------------
// khb_stream_if: valid/ready channel
// Generic payload channel with source and sink views.
// ----------------------------------------------------------------------------
interface khb_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/khb_ram.sv]
// ----------------------------------------------------------------------------
// khb_ram: single-port-write, single-read RAM
// Registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module khb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[rtl/khb_datapath.sv]
// ----------------------------------------------------------------------------
// khb_datapath: hash state, shared G lanes and bucket counter update
// Holds the 16-word state; a half-round runs four G mixers per cycle.
// ----------------------------------------------------------------------------
module khb_datapath import khb_pkg::*; #(
	parameter int NONCE_LEN    = NONCE_LEN_DEF,
	parameter int PREFIX_BYTES = PREFIX_BYTES_DEF
) (
	input  logic         clk,
	input  khb_cmd_t     cmd,
	output khb_sts_t     sts,
	input  logic [31:0]  nonce,
	input  logic [255:0] key,
	input  logic [15:0]  rpb,
	input  logic [31:0]  limit,
	input  logic         clr_we,
	input  logic [15:0]  clr_addr,
	output logic [31:0]  res_nonce,
	output logic [15:0]  res_bucket,
	output logic [15:0]  res_slot,
	output logic [31:0]  res_sidx,
	output logic [1:0]   res_status
);
	localparam int NB = (NONCE_LEN < 4) ? NONCE_LEN : 4;

	word_t       v_q [16];
	logic [31:0] m0_q;
	logic [31:0] nonce_q;
	logic [15:0] bucket_q;

	// message word 0 only; the rest are zero
	logic [31:0] m0_c;
	always_comb begin
		m0_c = '0;
		for (int i = 0; i < NB; i++) m0_c[8*i +: 8] = nonce[8*i +: 8];
	end

	assign sts.in_range = nonce < limit;

	function automatic word_t rr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	word_t v_n [16];
	always_comb begin
		logic [3:0] ia, ib, ic, id;
		word_t a, b, c, d, x, y;
		v_n = v_q;
		for (int g = 0; g < 4; g++) begin
			ia = 4'(g);
			ib = cmd.diag ? 4'(4 + ((g + 1) % 4)) : 4'(4 + g);
			ic = cmd.diag ? 4'(8 + ((g + 2) % 4)) : 4'(8 + g);
			id = cmd.diag ? 4'(12 + ((g + 3) % 4)) : 4'(12 + g);
			x = (msg_sel(cmd.rnd, {cmd.diag, 3'(2*g)}) == 4'd0) ? m0_q : '0;
			y = (msg_sel(cmd.rnd, {cmd.diag, 3'(2*g+1)}) == 4'd0) ? m0_q : '0;
			a = v_q[ia]; b = v_q[ib]; c = v_q[ic]; d = v_q[id];
			a = a + b + x;  d = rr(d ^ a, 16);
			c = c + d;      b = rr(b ^ c, 12);
			a = a + b + y;  d = rr(d ^ a, 8);
			c = c + d;      b = rr(b ^ c, 7);
			v_n[ia] = a; v_n[ib] = b; v_n[ic] = c; v_n[id] = d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= key[32*i +: 32];
			v_q[8] <= IV0; v_q[9] <= IV1; v_q[10] <= IV2; v_q[11] <= IV3;
			v_q[12] <= '0; v_q[13] <= '0;
			v_q[14] <= 32'(NONCE_LEN);
			v_q[15] <= FLAGS_KEYED;
			m0_q    <= m0_c;
			nonce_q <= nonce;
		end else if (cmd.half) begin
			v_q <= v_n;
		end
	end

	// bucket index from hash word 0 bytes, big-endian
	logic [31:0] w0;
	logic [23:0] pre;
	always_comb begin
		w0 = v_q[0] ^ v_q[8];
		pre = '0;
		for (int i = 0; i < PREFIX_BYTES; i++) pre = {pre[15:0], w0[8*i +: 8]};
	end

	always_ff @(posedge clk) if (cmd.mem_rd) bucket_q <= pre[15:0];

	logic [15:0] fill;
	logic        room;
	assign room = fill < rpb;

	khb_ram #(.WIDTH(16), .DEPTH(1 << BUCKET_AW)) u_fill (
		.clk   (clk),
		.we    (cmd.mem_wr | clr_we),
		.waddr (clr_we ? clr_addr : bucket_q),
		.wdata (clr_we ? 16'd0 : (room ? fill + 16'd1 : rpb)),
		.raddr (pre[15:0]),
		.rdata (fill)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			res_nonce  <= nonce;
			res_bucket <= '0;
			res_slot   <= '0;
			res_sidx   <= '0;
			res_status <= ST_RANGE;
		end else if (cmd.mem_wr) begin
			res_nonce  <= nonce_q;
			res_bucket <= bucket_q;
			res_slot   <= room ? fill : 16'd0;
			res_sidx   <= room ? 32'(bucket_q) * 32'(rpb) + {16'd0, fill} : 32'd0;
			res_status <= room ? ST_STORED : ST_FULL;
		end
	end
endmodule

[rtl/khb_ctrl.sv]
// ----------------------------------------------------------------------------
// khb_ctrl: sequencer for clear, hash rounds and counter update
// Clears the counter RAM after reset, then steps each transaction.
// ----------------------------------------------------------------------------
module khb_ctrl import khb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  khb_sts_t    sts,
	output khb_cmd_t    cmd,
	output logic        clr_we,
	output logic [15:0] clr_addr
);
	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_HASH = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_WR   = 3'd4;

	logic [2:0]  state_q;
	logic [3:0]  step_q;
	logic [15:0] clr_q;
	logic        outv_q;
	logic        take;

	// accept in idle when the result slot is free or drains this cycle
	assign in_ready  = (state_q == S_IDLE) && (!outv_q || out_ready);
	assign take      = in_valid && in_ready;
	assign out_valid = outv_q;
	assign clr_we    = state_q == S_CLR;
	assign clr_addr  = clr_q;

	always_comb begin
		cmd        = '0;
		cmd.start  = take;
		cmd.half   = state_q == S_HASH;
		cmd.diag   = step_q[0];
		cmd.rnd    = step_q[3:1];
		cmd.mem_rd = state_q == S_RD;
		cmd.mem_wr = state_q == S_WR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			step_q  <= '0;
			clr_q   <= '0;
			outv_q  <= 1'b0;
		end else begin
			// raise on a rejected nonce or a finished update, else drop once taken
			if ((take && !sts.in_range) || state_q == S_WR) outv_q <= 1'b1;
			else if (out_ready) outv_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 16'd1;
					if (clr_q == 16'hFFFF) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (take) begin
						step_q <= '0;
						if (sts.in_range) state_q <= S_HASH;
					end
				end
				S_HASH: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'(2*ROUNDS - 1)) state_q <= S_RD;
				end
				S_RD: state_q <= S_WR;
				S_WR: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/keyed_hash_bucket_insert_top.sv]
// Each in-range nonce runs 14 half-rounds on four shared G lanes, then a
// counter read and a counter write that also registers the result. New
// input waits until an in-range nonce is done; rejected nonces go at one
// per cycle while the result side keeps up.
// Reset: asynchronous, active low; then a pass over all 65536 addresses
// clears the bucket counter RAM, during which no input is accepted.
// ----------------------------------------------------------------------------
// keyed_hash_bucket_insert_top: keyed hash bucket insert
// Hashes each nonce below the limit under the key, bumps its bucket counter while it has room, reports a slot.
// ----------------------------------------------------------------------------
module keyed_hash_bucket_insert_top import khb_pkg::*; #(
	parameter int NONCE_LEN    = NONCE_LEN_DEF,
	parameter int PREFIX_BYTES = PREFIX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	khb_stream_if.sink   in_ch,
	khb_stream_if.source out_ch
);
	logic [255:0] key_q;
	logic [15:0]  rpb_q;
	logic [31:0]  limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			rpb_q   <= 16'd256;
			limit_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY01: key_q[63:0]    <= cfg_data;
				REG_KEY23: key_q[127:64]  <= cfg_data;
				REG_KEY45: key_q[191:128] <= cfg_data;
				REG_KEY67: key_q[255:192] <= cfg_data;
				REG_RPB:   rpb_q          <= cfg_data[15:0];
				REG_LIMIT: limit_q        <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	khb_cmd_t    cmd;
	khb_sts_t    sts;
	logic        clr_we;
	logic [15:0] clr_addr;

	khb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd), .clr_we(clr_we), .clr_addr(clr_addr)
	);

	khb_datapath #(.NONCE_LEN(NONCE_LEN), .PREFIX_BYTES(PREFIX_BYTES)) u_dp (
		.clk(clk), .cmd(cmd), .sts(sts),
		.nonce(in_ch.data.nonce), .key(key_q), .rpb(rpb_q), .limit(limit_q),
		.clr_we(clr_we), .clr_addr(clr_addr),
		.res_nonce(out_ch.data.nonce_out), .res_bucket(out_ch.data.bucket_index),
		.res_slot(out_ch.data.slot), .res_sidx(out_ch.data.storage_index),
		.res_status(out_ch.data.status)
	);
endmodule
